[hw/rtl/rmf_pkg.sv]
// Shared types and constants for the ratio and mutual match filter.
// No dependencies; every other file imports this package.
`default_nettype none

package rmf_pkg;

  localparam int unsigned IndexBits  = 10;
  localparam int unsigned DistBits   = 16;
  localparam int unsigned RatioBits  = 16;
  localparam int unsigned EntriesDef = 1024;

  localparam logic [RatioBits-1:0] RatioReset = 16'd42598;

  localparam logic [1:0] ActClear = 2'd0;
  localparam logic [1:0] ActLoad  = 2'd1;
  localparam logic [1:0] ActTest  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SEARCH = 2'd2
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]           action;
    logic [IndexBits-1:0] query_index;
    logic [IndexBits-1:0] train_index;
    logic [DistBits-1:0]  best_distance;
    logic [DistBits-1:0]  second_distance;
    logic                 has_second;
  } in_item_t;

  typedef struct packed {
    logic [IndexBits-1:0] kept_query;
    logic [IndexBits-1:0] kept_train;
    logic [DistBits-1:0]  kept_distance;
  } out_item_t;

  typedef struct packed {
    cmd_op_e              op;
    logic [IndexBits-1:0] query;
    logic [IndexBits-1:0] train;
    logic [DistBits-1:0]  distance;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/ratio_and_mutual_match_filter.sv]
// Ratio-test and cross-check filter for nearest-neighbour feature matches.
// Top level; depends on rmf_pkg, rmf_front, rmf_queue and rmf_back.
//
// Each request is classified in the cycle it is accepted and queued (two
// deep) for the back end, which carries out a clear or a load as it pops
// it. A test that passes the ratio test scans a non-empty backward table
// one entry per cycle through the single read port of the table memory,
// stopping at the first match or after the last filled entry; a stalled
// result holds the back end until it is taken. Loads and tests that fail
// the ratio test, and unused action codes, are dropped at the front end
// in their accept cycle.
// The table needs no clearing pass after reset; only entries below the
// fill count are ever read.
`default_nettype none

module ratio_and_mutual_match_filter
  import rmf_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [RatioBits-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire in_item_t             in_item_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      out_item_t            out_item_o
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd_out;

  rmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in)
  );

  rmf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  rmf_back #(
    .Entries (ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

[hw/rtl/rmf_front.sv]
// Front end: accepts requests, applies the ratio test and classifies them.
// Depends on rmf_pkg; feeds rmf_queue.
`default_nettype none

module rmf_front
  import rmf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [RatioBits-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire in_item_t             in_item_i,
  input  wire logic                 q_full_i,
  output      logic                 q_push_o,
  output      cmd_t                 q_cmd_o
);

  logic [RatioBits-1:0] ratio_q, ratio_d;
  logic [31:0]          prod;
  logic [31:0]          best_sh;
  logic                 ratio_ok;
  logic                 accept;

  always_comb begin
    ratio_d = ratio_q;
    if (cfg_we_i) begin
      ratio_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatioReset;
    end else begin
      ratio_q <= ratio_d;
    end
  end

  assign prod     = {16'b0, ratio_q} * {{(32 - DistBits){1'b0}}, in_item_i.second_distance};
  assign best_sh  = {in_item_i.best_distance, 16'b0};
  assign ratio_ok = in_item_i.has_second && (best_sh <= prod);

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    q_push_o         = 1'b0;
    q_cmd_o.op       = OP_CLEAR;
    q_cmd_o.query    = in_item_i.query_index;
    q_cmd_o.train    = in_item_i.train_index;
    q_cmd_o.distance = in_item_i.best_distance;
    unique case (in_item_i.action)
      ActClear: begin
        q_push_o   = accept;
        q_cmd_o.op = OP_CLEAR;
      end
      ActLoad: begin
        q_push_o   = accept && ratio_ok;
        q_cmd_o.op = OP_LOAD;
      end
      ActTest: begin
        q_push_o   = accept && ratio_ok;
        q_cmd_o.op = OP_SEARCH;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/rmf_queue.sv]
// Two-entry command queue between front end and back end.
// Depends on rmf_pkg.
`default_nettype none

module rmf_queue
  import rmf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      logic valid_o,
  output      cmd_t cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rmf_back.sv]
// Back end: backward table memory, fill count, linear search and result register.
// Depends on rmf_pkg; drains rmf_queue.
`default_nettype none

module rmf_back
  import rmf_pkg::*;
#(
  parameter int unsigned Entries = EntriesDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  input  wire cmd_t      q_cmd_i,
  output      logic      q_pop_o,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_item_o
);

  localparam int unsigned AddrW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned FillW = $clog2(Entries + 1);
  localparam int unsigned WordW = 2 * IndexBits;
  localparam logic [FillW-1:0] FillMax = FillW'(Entries);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [WordW-1:0] table_mem [Entries];

  logic [1:0]       state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] idx_q, idx_d;
  cmd_t             cmd_q, cmd_d;
  logic [WordW-1:0] rdata_q;
  logic             rvalid_q;
  logic             rd_en;
  logic             hit;
  logic             wr_en;
  logic [WordW-1:0] want;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             out_free;

  assign want     = {q_cmd_i.train, q_cmd_i.query};
  assign hit      = (state_q == StScan) && rvalid_q &&
                    (rdata_q == {cmd_q.train, cmd_q.query});
  assign rd_en    = (state_q == StScan) && (idx_q < fill_q) && !hit;
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == StIdle) && q_valid_i;
  assign wr_en    = q_pop_o && (q_cmd_i.op == OP_LOAD) && (fill_q < FillMax);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          unique case (q_cmd_i.op)
            OP_CLEAR: begin
              fill_d = '0;
            end
            OP_LOAD: begin
              if (wr_en) begin
                fill_d = fill_q + 1'b1;
              end
            end
            OP_SEARCH: begin
              if (fill_q != '0) begin
                cmd_d   = q_cmd_i;
                idx_d   = '0;
                state_d = StScan;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StScan: begin
        if (hit) begin
          state_d = StOut;
        end else if (rd_en) begin
          idx_d = idx_q + 1'b1;
        end else if (!rvalid_q) begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.kept_query    = cmd_q.query;
          out_d.kept_train    = cmd_q.train;
          out_d.kept_distance = cmd_q.distance;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      rvalid_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[fill_q[AddrW-1:0]] <= want ^ {q_cmd_i.train ^ q_cmd_i.query,
                                              q_cmd_i.query ^ q_cmd_i.train};
    end
    if (rd_en) begin
      rdata_q <= table_mem[idx_q[AddrW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[hw/rtl/rmf_checker.sv]
// Port-level checks for the ratio and mutual match filter, bound to its top level.
// Depends on rmf_pkg and ratio_and_mutual_match_filter.
`default_nettype none

module rmf_port_checks
  import rmf_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("outputs active during reset");

  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall raised without a preceding request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

endmodule

bind ratio_and_mutual_match_filter rmf_port_checks u_rmf_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

[tb/rmf_checker.sv]
// Checker for the ratio and mutual match filter: mirrors the ratio register and
// the backward table, predicts every kept match and compares it on the output.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_checker
  import rmf_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [RatioBits-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire in_item_t             in_item_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire out_item_t            out_item_i,
  input  wire logic                 end_check_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               requests_o,
  output int unsigned               kept_o
);

  logic [RatioBits-1:0]     ratio_limit;
  logic [2*IndexBits-1:0]   bwd_pairs [ENTRIES];
  int unsigned              pair_count;
  out_item_t                kept_expected [$];
  int unsigned              mismatches;
  int unsigned              requests_seen;
  int unsigned              kept_seen;
  logic                     end_checked;

  function automatic logic ratio_passes(input logic [RatioBits-1:0] limit,
                                        input in_item_t req);
    logic [47:0] scaled_best;
    logic [47:0] scaled_second;
    scaled_best   = {16'd0, req.best_distance, 16'd0};
    scaled_second = 48'(limit) * 48'(req.second_distance);
    return req.has_second && (scaled_best <= scaled_second);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 20) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    in_item_t  req;
    out_item_t oldest;
    out_item_t fresh;
    logic      found;
    if (!rst_ni) begin
      ratio_limit = RatioReset;
      pair_count  = 0;
      kept_expected.delete();
      mismatches    = 0;
      requests_seen = 0;
      kept_seen     = 0;
      end_checked   = 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        kept_seen++;
        if (kept_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected kept match q=%0d t=%0d d=%0d",
                                    out_item_i.kept_query, out_item_i.kept_train,
                                    out_item_i.kept_distance));
        end else begin
          oldest = kept_expected.pop_front();
          if (out_item_i.kept_query !== oldest.kept_query) begin
            report_mismatch($sformatf("kept_query %0d, want %0d",
                                      out_item_i.kept_query, oldest.kept_query));
          end
          if (out_item_i.kept_train !== oldest.kept_train) begin
            report_mismatch($sformatf("kept_train %0d, want %0d",
                                      out_item_i.kept_train, oldest.kept_train));
          end
          if (out_item_i.kept_distance !== oldest.kept_distance) begin
            report_mismatch($sformatf("kept_distance %0d, want %0d",
                                      out_item_i.kept_distance, oldest.kept_distance));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        requests_seen++;
        req = in_item_i;
        case (req.action)
          ActClear: begin
            pair_count = 0;
          end
          ActLoad: begin
            if (ratio_passes(ratio_limit, req) && pair_count < ENTRIES) begin
              bwd_pairs[pair_count] = {req.query_index, req.train_index};
              pair_count++;
            end
          end
          ActTest: begin
            if (ratio_passes(ratio_limit, req)) begin
              found = 1'b0;
              for (int unsigned k = 0; k < pair_count; k++) begin
                if (bwd_pairs[k] == {req.train_index, req.query_index}) found = 1'b1;
              end
              if (found) begin
                fresh.kept_query    = req.query_index;
                fresh.kept_train    = req.train_index;
                fresh.kept_distance = req.best_distance;
                kept_expected.insert(kept_expected.size(), fresh);
              end
            end
          end
          default: ;
        endcase
      end
      if (cfg_we_i) ratio_limit = cfg_wdata_i;
      if (end_check_i && !end_checked) begin
        end_checked = 1'b1;
        if (kept_expected.size() != 0) begin
          report_mismatch($sformatf("%0d kept matches never came out",
                                    kept_expected.size()));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= unsigned'(kept_expected.size());
    requests_o   <= requests_seen;
    kept_o       <= kept_seen;
  end

endmodule

[tb/tb_top.sv]
// Testbench top for ratio_and_mutual_match_filter: clock, reset, request and
// ratio stimulus, result stall, watchdog and verdict. Depends on rmf_pkg,
// the filter RTL and rmf_checker.
`timescale 1ns / 1ps

module tb_top;
  import rmf_pkg::*;

  localparam logic [1:0]           ActUnused     = 2'd3;
  localparam logic [RatioBits-1:0] RatioMax      = '1;
  localparam int unsigned          RandomItems   = 540;
  localparam int unsigned          SettleCycles  = 3 * (EntriesDef + 8);
  localparam int unsigned          WatchdogLimit = 16 * (EntriesDef + 8);

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [RatioBits-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 end_check;

  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          requests_seen;
  int unsigned          kept_seen;
  int unsigned          quiet_cycles;
  int unsigned          ratio_writes;
  logic [RatioBits-1:0] ratio_now;
  logic                 idle_free;
  logic                 stall_free;

  ratio_and_mutual_match_filter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  rmf_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .end_check_i  (end_check),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .requests_o   (requests_seen),
    .kept_o       (kept_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_request(input logic [1:0]           act,
                                            input logic [IndexBits-1:0] q,
                                            input logic [IndexBits-1:0] t,
                                            input logic [DistBits-1:0]  best,
                                            input logic [DistBits-1:0]  second,
                                            input logic                 has2);
    return '{action: act, query_index: q, train_index: t, best_distance: best,
             second_distance: second, has_second: has2};
  endfunction

  function automatic in_item_t passing_request(input logic [1:0]           act,
                                               input logic [IndexBits-1:0] q,
                                               input logic [IndexBits-1:0] t);
    logic [DistBits-1:0] second;
    logic [47:0]         cap;
    second = DistBits'($urandom);
    cap    = (48'(ratio_now) * 48'(second)) >> RatioBits;
    return make_request(act, q, t, DistBits'($urandom_range(32'(cap), 0)), second, 1'b1);
  endfunction

  function automatic in_item_t noise_request();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = idle_free ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_ratio(input logic [RatioBits-1:0] value);
    settle_block();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ratio_now = value;
    ratio_writes++;
  endtask

  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b1;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = stall_free ? 0 : $urandom_range(0, 15);
      if (!stall_free && $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        @(negedge clk);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    in_item_t               req;
    logic [2*IndexBits-1:0] loaded_pairs [$];
    logic [2*IndexBits-1:0] pair;
    logic [IndexBits-1:0]   q;
    logic [IndexBits-1:0]   t;
    logic [RatioBits-1:0]   next_ratio;
    int unsigned            n_loads;
    int unsigned            n_tests;
    int unsigned            pick;
    int unsigned            random_sent;
    int unsigned            phase;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_item      = '0;
    end_check    = 1'b0;
    idle_free    = 1'b0;
    stall_free   = 1'b0;
    ratio_writes = 0;
    ratio_now    = RatioReset;
    random_sent  = 0;
    phase        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(make_request(ActClear, '0, '0, '0, '0, 1'b0));
    send_request(make_request(ActLoad, 10'd3, 10'd9, 16'd5, 16'd10, 1'b0));
    send_request(make_request(ActLoad, 10'd0, 10'd1023, 16'd0, 16'd0, 1'b1));
    send_request(make_request(ActLoad, 10'd1023, 10'd0, 16'd65535, 16'd65535, 1'b1));
    send_request(make_request(ActLoad, 10'd5, 10'd7, 16'd100, 16'd200, 1'b1));
    send_request(make_request(ActLoad, 10'd1023, 10'd0, 16'd0, 16'd65535, 1'b1));
    send_request(make_request(ActTest, 10'd1023, 10'd0, 16'd0, 16'd0, 1'b1));
    send_request(make_request(ActTest, 10'd7, 10'd5, 16'd1, 16'd0, 1'b1));
    send_request(make_request(ActTest, 10'd7, 10'd5, 16'd10, 16'd100, 1'b0));
    send_request(make_request(ActTest, 10'd7, 10'd5, 16'd21299, 16'd32768, 1'b1));
    send_request(make_request(ActTest, 10'd7, 10'd5, 16'd21300, 16'd32768, 1'b1));
    send_request(make_request(ActTest, 10'd0, 10'd1023, 16'd65535, 16'd65535, 1'b1));
    send_request(make_request(ActTest, 10'd0, 10'd1023, 16'd0, 16'd65535, 1'b1));
    send_request(make_request(ActUnused, 10'd7, 10'd5, 16'd10, 16'd100, 1'b1));
    send_request(make_request(ActTest, 10'd9, 10'd3, 16'd5, 16'd10, 1'b1));
    send_request(make_request(ActTest, 10'd1, 10'd2, 16'd1, 16'd2, 1'b1));
    send_request(make_request(ActClear, 10'd1023, 10'd1023, '1, '1, 1'b1));
    send_request(make_request(ActTest, 10'd7, 10'd5, 16'd10, 16'd100, 1'b1));

    while (random_sent < RandomItems) begin
      if (phase == 0) begin
        next_ratio = '0;
      end else begin
        case ($urandom_range(0, 4))
          0: next_ratio = RatioMax;
          1: next_ratio = RatioReset;
          default: next_ratio = RatioBits'($urandom);
        endcase
      end
      write_ratio(next_ratio);
      phase++;
      idle_free  = ($urandom_range(0, 4) == 0);
      stall_free = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        req = noise_request();
        req.action = ActClear;
        send_request(req);
        loaded_pairs.delete();
      end
      n_loads = $urandom_range(1, 24);
      n_tests = $urandom_range(1, 24);
      for (int unsigned k = 0; k < n_loads + n_tests; k++) begin
        pick = $urandom_range(0, 9);
        q    = IndexBits'($urandom);
        t    = IndexBits'($urandom);
        if (pick == 0) begin
          req = noise_request();
        end else if (k < n_loads) begin
          req = passing_request(ActLoad, q, t);
          if (pick == 1) req.has_second = 1'b0;
          else loaded_pairs.insert(loaded_pairs.size(), {q, t});
        end else if (pick <= 2 || loaded_pairs.size() == 0) begin
          req = passing_request(ActTest, q, t);
        end else begin
          pair = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
          req  = passing_request(ActTest, pair[IndexBits-1:0], pair[2*IndexBits-1:IndexBits]);
          case (pick)
            3: req.train_index[$urandom_range(0, IndexBits - 1)] ^= 1'b1;
            4: req.has_second = 1'b0;
            5: req.best_distance = req.second_distance;
            default: ;
          endcase
        end
        send_request(req);
        if (req.action != ActUnused) random_sent++;
      end
    end

    settle_block();
    end_check <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    $display("covered %0d requests over %0d ratio settings, %0d kept matches compared,",
             requests_seen, ratio_writes, kept_seen);
    $display("including ratio limits of zero and maximum, unused actions and stalled results");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rmf_pkg.sv
hw/rtl/rmf_front.sv
hw/rtl/rmf_queue.sv
hw/rtl/rmf_back.sv
hw/rtl/ratio_and_mutual_match_filter.sv
hw/rtl/rmf_checker.sv
tb/rmf_checker.sv
tb/tb_top.sv
